// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clock.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every edge outside reset
`define EGCD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every edge, reset included
`define EGCD_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/egcd_pkg.sv =====
// ----------------------------------------------------------------------------
// egcd_pkg
// Shared constants and control types for the extended GCD block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package egcd_pkg;

   // Default operand width
   localparam int WIDTH_DEFAULT = 32;

   // Sequencer to divider control
   typedef struct packed {
      logic start;
   } egcd_div_ctl_type;

   // Divider status back to sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } egcd_div_sts_type;

endpackage

// ===== rtl/extended_gcd_bezout.sv =====
// Sequence: a zero operand goes straight to the result; otherwise each Euclid
//   quotient step starts the bit-serial divider, then updates on its done.
// Throughput: one item at a time; a new item is taken once the previous result
//   sits in the output register, even while that result still waits.
// Reset: synchronous, active high; clears sequencer and output valid.
// ----------------------------------------------------------------------------
// extended_gcd_bezout
// Extended Euclid on operand magnitudes with sign restore: returns
// g = gcd(|a|,|b|) and x, y with a*x - b*y = g.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module extended_gcd_bezout #(
   parameter int WIDTH = egcd_pkg::WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: a [WIDTH-1:0], b [2*WIDTH-1:WIDTH], zero pad to bytes
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [((2*WIDTH+7)/8)*8-1:0]        req_tdata,
   // rsp_tdata: gcd_value [WIDTH-2:0], coef_x, coef_y, zero pad to bytes
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [((3*WIDTH-1+7)/8)*8-1:0]      rsp_tdata
);

   localparam int OUT_W = ((3*WIDTH-1+7)/8)*8;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_START,
      ST_DIV,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic             a_neg_ff, a_neg_in;
   logic             b_neg_ff, b_neg_in;
   logic [WIDTH-1:0] r0_ff, r0_in;
   logic [WIDTH-1:0] r1_ff, r1_in;
   logic [WIDTH-1:0] ca0_ff, ca0_in;
   logic [WIDTH-1:0] ca1_ff, ca1_in;
   logic [WIDTH-1:0] cb0_ff, cb0_in;
   logic [WIDTH-1:0] cb1_ff, cb1_in;
   logic [WIDTH-2:0] g_ff, g_in;
   logic [WIDTH-1:0] x_ff, x_in;
   logic [WIDTH-1:0] y_ff, y_in;
   logic [WIDTH-2:0] rsp_g_ff, rsp_g_in;
   logic [WIDTH-1:0] rsp_x_ff, rsp_x_in;
   logic [WIDTH-1:0] rsp_y_ff, rsp_y_in;

   logic [WIDTH-1:0] op_a, op_b, mag_a, mag_b;
   logic             load_rsp;

   egcd_pkg::egcd_div_ctl_type div_ctl;
   egcd_pkg::egcd_div_sts_type div_sts;
   logic [WIDTH-1:0] div_rem, div_pa, div_pb;

   // Operand unpack and magnitudes
   assign op_a  = req_tdata[WIDTH-1:0];
   assign op_b  = req_tdata[2*WIDTH-1:WIDTH];
   assign mag_a = op_a[WIDTH-1] ? (~op_a + 1'b1) : op_a;
   assign mag_b = op_b[WIDTH-1] ? (~op_b + 1'b1) : op_b;

   assign req_tready    = (state_ff == ST_IDLE);
   assign div_ctl.start = (state_ff == ST_START);
   assign load_rsp      = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_tready);

   // Shared divider / product unit
   egcd_divider #(
      .WIDTH (WIDTH)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .ctl       (div_ctl),
      .sts       (div_sts),
      .dividend  (r0_ff),
      .divisor   (r1_ff),
      .mul_a     (ca1_ff),
      .mul_b     (cb1_ff),
      .remainder (div_rem),
      .prod_a    (div_pa),
      .prod_b    (div_pb)
   );

   // Sequencer and datapath next state
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      a_neg_in     = a_neg_ff;
      b_neg_in     = b_neg_ff;
      r0_in        = r0_ff;
      r1_in        = r1_ff;
      ca0_in       = ca0_ff;
      ca1_in       = ca1_ff;
      cb0_in       = cb0_ff;
      cb1_in       = cb1_ff;
      g_in         = g_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      rsp_g_in     = rsp_g_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               a_neg_in = op_a[WIDTH-1];
               b_neg_in = op_b[WIDTH-1];
               if (op_a == '0 && op_b == '0) begin
                  g_in     = '0;
                  x_in     = '0;
                  y_in     = '0;
                  state_in = ST_FINISH;
               end else if (op_a == '0) begin
                  g_in     = mag_b[WIDTH-2:0];
                  x_in     = '0;
                  y_in     = op_b[WIDTH-1] ? WIDTH'(1) : '1;
                  state_in = ST_FINISH;
               end else if (op_b == '0) begin
                  g_in     = mag_a[WIDTH-2:0];
                  x_in     = op_a[WIDTH-1] ? '1 : WIDTH'(1);
                  y_in     = '0;
                  state_in = ST_FINISH;
               end else begin
                  r0_in    = mag_a;
                  r1_in    = mag_b;
                  ca0_in   = WIDTH'(1);
                  ca1_in   = '0;
                  cb0_in   = '0;
                  cb1_in   = WIDTH'(1);
                  state_in = ST_START;
               end
            end
         end
         ST_START: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_sts.done) begin
               if (div_rem == '0) begin
                  // Last nonzero remainder is the gcd; restore signs
                  g_in     = r1_ff[WIDTH-2:0];
                  x_in     = a_neg_ff ? (~ca1_ff + 1'b1) : ca1_ff;
                  y_in     = b_neg_ff ? cb1_ff : (~cb1_ff + 1'b1);
                  state_in = ST_FINISH;
               end else begin
                  // Euclid step: shift remainders, update coefficients
                  r0_in    = r1_ff;
                  r1_in    = div_rem;
                  ca0_in   = ca1_ff;
                  ca1_in   = ca0_ff - div_pa;
                  cb0_in   = cb1_ff;
                  cb1_in   = cb0_ff - div_pb;
                  state_in = ST_START;
               end
            end
         end
         ST_FINISH: begin
            if (load_rsp) begin
               rsp_g_in     = g_ff;
               rsp_x_in     = x_ff;
               rsp_y_in     = y_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and result registers
   always_ff @(posedge clock) begin
      a_neg_ff <= a_neg_in;
      b_neg_ff <= b_neg_in;
      r0_ff    <= r0_in;
      r1_ff    <= r1_in;
      ca0_ff   <= ca0_in;
      ca1_ff   <= ca1_in;
      cb0_ff   <= cb0_in;
      cb1_ff   <= cb1_in;
      g_ff     <= g_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      rsp_g_ff <= rsp_g_in;
      rsp_x_ff <= rsp_x_in;
      rsp_y_ff <= rsp_y_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = OUT_W'({rsp_y_ff, rsp_x_ff, rsp_g_ff});

   // Assertions
   `EGCD_ASSERT_ALWAYS(a_reset_idle, reset |=> (state_ff == ST_IDLE && !rsp_tvalid), "reset did not idle the block")
   `EGCD_ASSERT(a_accept_next, (req_tvalid && req_tready) |=> (state_ff == ST_START || state_ff == ST_FINISH), "bad state after accept")
   `EGCD_ASSERT(a_start_free, div_ctl.start |-> !div_sts.busy, "divider started while busy")
   `EGCD_ASSERT(a_done_in_div, div_sts.done |-> (state_ff == ST_DIV), "divider done outside divide state")

endmodule

// ===== rtl/egcd_divider.sv =====
// ----------------------------------------------------------------------------
// egcd_divider
// Restoring divider, one quotient bit per cycle. While the quotient bits come
// out MSB first, it also accumulates q*mul_a and q*mul_b (mod 2^WIDTH) by
// shift-and-add, giving the products for the coefficient update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module egcd_divider #(
   parameter int WIDTH = egcd_pkg::WIDTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  egcd_pkg::egcd_div_ctl_type  ctl,
   output egcd_pkg::egcd_div_sts_type  sts,
   input  logic [WIDTH-1:0]            dividend,
   input  logic [WIDTH-1:0]            divisor,
   input  logic [WIDTH-1:0]            mul_a,
   input  logic [WIDTH-1:0]            mul_b,
   output logic [WIDTH-1:0]            remainder,
   output logic [WIDTH-1:0]            prod_a,
   output logic [WIDTH-1:0]            prod_b
);

   localparam int CNT_W = $clog2(WIDTH + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] dvd_ff, dvd_in;
   logic [WIDTH-1:0] dvs_ff, dvs_in;
   logic [WIDTH-1:0] mla_ff, mla_in;
   logic [WIDTH-1:0] mlb_ff, mlb_in;
   logic [WIDTH-1:0] pra_ff, pra_in;
   logic [WIDTH-1:0] prb_ff, prb_in;

   logic [WIDTH:0]   trial;
   logic [WIDTH:0]   diff;
   logic             qbit;

   // One restoring step: shift in next dividend bit, trial subtract
   assign trial = {rem_ff, dvd_ff[WIDTH-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign qbit  = ~diff[WIDTH];

   // Control next state
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(WIDTH);
      end else if (busy_ff) begin
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Datapath next state
   always_comb begin
      rem_in = rem_ff;
      dvd_in = dvd_ff;
      dvs_in = dvs_ff;
      mla_in = mla_ff;
      mlb_in = mlb_ff;
      pra_in = pra_ff;
      prb_in = prb_ff;
      if (ctl.start) begin
         rem_in = '0;
         dvd_in = dividend;
         dvs_in = divisor;
         mla_in = mul_a;
         mlb_in = mul_b;
         pra_in = '0;
         prb_in = '0;
      end else if (busy_ff) begin
         rem_in = qbit ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
         dvd_in = {dvd_ff[WIDTH-2:0], 1'b0};
         pra_in = {pra_ff[WIDTH-2:0], 1'b0} + (qbit ? mla_ff : '0);
         prb_in = {prb_ff[WIDTH-2:0], 1'b0} + (qbit ? mlb_ff : '0);
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      mla_ff <= mla_in;
      mlb_ff <= mlb_in;
      pra_ff <= pra_in;
      prb_ff <= prb_in;
   end

   assign sts.busy  = busy_ff;
   assign sts.done  = done_ff;
   assign remainder = rem_ff;
   assign prod_a    = pra_ff;
   assign prod_b    = prb_ff;

endmodule
